/* hw/rtl/otpdt_pkg.sv */
// ----------------------------------------------------------------------------
// otpdt_pkg
// Shared types and constants for the OTP digest truncation unit.
// ----------------------------------------------------------------------------
package otpdt_pkg;

	localparam int MAX_DIGEST_BYTES = 64;
	localparam int MIN_DIGEST_BYTES = 20;
	localparam int HEAD_DEPTH       = 19;
	localparam int OUTPUT_DIGITS    = 8;
	localparam int VALUE_BITS       = 32;

	localparam int POS_W    = $clog2(MAX_DIGEST_BYTES);
	localparam int LEN_W    = 7;
	localparam int CDIG_W   = 4;
	localparam int HEAD_AW  = $clog2(HEAD_DEPTH);
	localparam int BIT_W    = $clog2(VALUE_BITS);
	localparam int DIG_W    = $clog2(OUTPUT_DIGITS);
	localparam int NIB_W    = 4;
	localparam int BCD_W    = OUTPUT_DIGITS * NIB_W;
	localparam int CHAR_W   = 6;

	localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(64);
	localparam logic [CDIG_W-1:0] CDIG_RESET  = CDIG_W'(8);
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);

	// register word index (paddr[2])
	localparam logic REG_DIGEST_LENGTH = 1'b0;
	localparam logic REG_CODE_DIGITS   = 1'b1;

	typedef struct packed {
		logic clr;
		logic shift;
		logic bit_in;
		logic pop;
	} otpdt_dab_ctrl_t;

endpackage

/* hw/rtl/otpdt_dabble.sv */
// ----------------------------------------------------------------------------
// otpdt_dabble
// Bit-serial binary to BCD shift register; keeps the low decimal digits and
// shifts them out one digit at a time, most significant first.
// ----------------------------------------------------------------------------
module otpdt_dabble
	import otpdt_pkg::*;
(
	input  logic                  clk,
	input  otpdt_dab_ctrl_t       ctrl,
	output logic [NIB_W-1:0]      top_nib
);

	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < OUTPUT_DIGITS; i++) begin
			if (bcd_q[i*NIB_W +: NIB_W] >= NIB_W'(5)) begin
				adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W] + NIB_W'(3);
			end else begin
				adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W];
			end
		end
	end

	// carry out of the top digit is dropped: value kept modulo 10^digits
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			bcd_q <= '0;
		end else if (ctrl.shift) begin
			bcd_q <= {adj[BCD_W-2:0], ctrl.bit_in};
		end else if (ctrl.pop) begin
			bcd_q <= {bcd_q[BCD_W-NIB_W-1:0], NIB_W'(0)};
		end
	end

	assign top_nib = bcd_q[BCD_W-1 -: NIB_W];

endmodule

/* hw/rtl/otp_digest_truncate_to_digits_unit.sv */
// ----------------------------------------------------------------------------
// otp_digest_truncate_to_digits_unit
// HOTP dynamic truncation of a digest into eight ASCII decimal digits.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, digest_byte): one digest byte per
// transaction. Bytes 0..18 are kept in a small head memory. The byte at
// position digest_length-1 (clamped to 20..64) closes the digest: its low
// nibble selects four kept bytes, which are fed bit by bit into a BCD
// shift register. The code is then reduced modulo 10^code_digits by
// blanking the upper digits.
// Output channel (out_valid/out_ready, digit_char, last_digit): eight
// transactions, most significant digit first, last_digit on the eighth.
// The first digit is offered once the bit-serial conversion is done; then
// one digit per cycle while out_ready is high. Bytes are taken one per
// cycle; during the conversion in_ready is low, and while digits drain
// new bytes are taken unless one would close the next digest.
// A receiver stall holds the current digit. Reset clears the position
// counter and state and loads digest_length=64, code_digits=8; the head
// memory is not cleared.
// APB: word 0 digest_length, word 1 code_digits; pready tied high.
// ----------------------------------------------------------------------------
module otp_digest_truncate_to_digits_unit
	import otpdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        digest_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last_digit
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    dlen_q;
	logic [CDIG_W-1:0]   cdig_q;
	logic [POS_W-1:0]    pos_q;
	logic [3:0]          off_q;
	logic [BIT_W-1:0]    bit_q;
	logic [DIG_W-1:0]    dig_q;
	logic [7:0]          sh_q;
	logic [7:0]          rdata_q;
	logic [7:0]          head_mem [HEAD_DEPTH];

	logic [LEN_W-1:0]    len_eff;
	logic                is_last;
	logic                in_fire;
	logic                out_fire;
	logic                cfg_wr;
	logic [BIT_W-1:0]    bit_nxt;
	logic [HEAD_AW-1:0]  rd_addr;
	logic                bit_in;
	logic [CDIG_W-1:0]   keep_digits;
	logic [NIB_W-1:0]    top_nib;
	logic [NIB_W-1:0]    shown_nib;
	otpdt_dab_ctrl_t     dab_ctrl;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q <= LEN_RESET;
			cdig_q <= CDIG_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DIGEST_LENGTH: dlen_q <= pwdata[LEN_W-1:0];
				REG_CODE_DIGITS:   cdig_q <= pwdata[CDIG_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DIGEST_LENGTH: prdata = {{(32-LEN_W){1'b0}}, dlen_q};
			REG_CODE_DIGITS:   prdata = {{(32-CDIG_W){1'b0}}, cdig_q};
			default:           prdata = '0;
		endcase
	end

	// position tracking
	always_comb begin
		if (dlen_q < LEN_W'(MIN_DIGEST_BYTES)) begin
			len_eff = LEN_W'(MIN_DIGEST_BYTES);
		end else if (dlen_q > LEN_W'(MAX_DIGEST_BYTES)) begin
			len_eff = LEN_W'(MAX_DIGEST_BYTES);
		end else begin
			len_eff = dlen_q;
		end
	end

	assign is_last  = (LEN_W'(pos_q) + LEN_W'(1)) >= len_eff;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_EMIT) && !is_last);
	assign in_fire  = in_valid && in_ready;
	assign out_valid = (state_q == S_EMIT);
	assign out_fire  = out_valid && out_ready;

	// head memory
	always_ff @(posedge clk) begin
		if (in_fire && (pos_q < POS_W'(HEAD_DEPTH))) begin
			head_mem[pos_q[HEAD_AW-1:0]] <= digest_byte;
		end
	end

	assign bit_nxt = bit_q + BIT_W'(1);
	assign rd_addr = (state_q == S_CONV) ?
		(HEAD_AW'(off_q) + HEAD_AW'(bit_nxt[BIT_W-1:3])) : HEAD_AW'(digest_byte[3:0]);

	always_ff @(posedge clk) begin
		rdata_q <= head_mem[rd_addr];
	end

	// serial bit source: top bit of the first byte forced to zero
	always_comb begin
		if (bit_q == '0) begin
			bit_in = 1'b0;
		end else if (bit_q[2:0] == 3'd0) begin
			bit_in = rdata_q[7];
		end else begin
			bit_in = sh_q[7];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CONV) begin
			if (bit_q[2:0] == 3'd0) begin
				sh_q <= {rdata_q[6:0], 1'b0};
			end else begin
				sh_q <= {sh_q[6:0], 1'b0};
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			off_q   <= '0;
			bit_q   <= '0;
			dig_q   <= '0;
		end else begin
			if (in_fire) begin
				if (is_last) begin
					pos_q <= '0;
					off_q <= digest_byte[3:0];
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && is_last) begin
						bit_q   <= '0;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					bit_q <= bit_nxt;
					if (bit_q == BIT_W'(VALUE_BITS-1)) begin
						dig_q   <= DIG_W'(OUTPUT_DIGITS-1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						dig_q <= dig_q - DIG_W'(1);
						if (dig_q == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		dab_ctrl.clr    = (state_q == S_IDLE) && in_fire && is_last;
		dab_ctrl.shift  = (state_q == S_CONV);
		dab_ctrl.bit_in = bit_in;
		dab_ctrl.pop    = out_fire;
	end

	otpdt_dabble u_dabble (
		.clk     (clk),
		.ctrl    (dab_ctrl),
		.top_nib (top_nib)
	);

	// digits at or above code_digits are zero after the modulo
	assign keep_digits = (cdig_q > CDIG_W'(OUTPUT_DIGITS)) ? CDIG_W'(OUTPUT_DIGITS) : cdig_q;
	assign shown_nib   = (CDIG_W'(dig_q) < keep_digits) ? top_nib : NIB_W'(0);
	assign digit_char  = ASCII_ZERO + CHAR_W'(shown_nib);
	assign last_digit  = (dig_q == '0);

endmodule

/* hw/rtl/otpdt_checker.sv */
// ----------------------------------------------------------------------------
// otpdt_checker
// Port-level checks for the OTP digest truncation unit.
// ----------------------------------------------------------------------------
module otpdt_checker
	import otpdt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] digit_char,
	input logic              last_digit
);

	logic [DIG_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q + DIG_W'(1);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
		else $error("digit transaction changed while stalled");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_digit == (cnt_q == DIG_W'(OUTPUT_DIGITS-1))))
		else $error("last_digit not on the final digit of a code");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_digit |=> !out_valid)
		else $error("digit offered right after the final digit");

	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("digit offered out of reset");

endmodule

bind otp_digest_truncate_to_digits_unit otpdt_checker u_otpdt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digit_char (digit_char),
	.last_digit (last_digit)
);

/* test/otpdt_digit_checker.sv */
// ----------------------------------------------------------------------------
// otpdt_digit_checker
// Watches the digest byte stream, the register writes and the digit stream
// of the OTP truncation unit. Keeps its own copy of the position counter,
// head bytes and registers, computes the eight digits each closing byte
// must produce, and compares every digit transaction against the oldest
// pending one.
// ----------------------------------------------------------------------------
module otpdt_digit_checker
	import otpdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        digest_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CHAR_W-1:0] digit_char,
	input  logic              last_digit,
	output int                errors,
	output int                outstanding
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} code_digit_t;

	code_digit_t      pending_digits[$];
	logic [LEN_W-1:0]  digest_len;
	logic [CDIG_W-1:0] digit_count;
	logic [7:0]        head_mem[HEAD_DEPTH];
	logic [6:0]        byte_pos;
	int                mismatches;

	task automatic absorb_digest_byte(input logic [7:0] b);
		int unsigned       eff;
		int unsigned       pos;
		int unsigned       off;
		int unsigned       i;
		logic [30:0]       word;
		longint unsigned   modulus;
		longint unsigned   code;
		code_digit_t       digits[OUTPUT_DIGITS];
		eff = digest_len;
		if (eff < MIN_DIGEST_BYTES)
			eff = MIN_DIGEST_BYTES;
		if (eff > MAX_DIGEST_BYTES)
			eff = MAX_DIGEST_BYTES;
		pos = byte_pos;
		if (pos < HEAD_DEPTH)
			head_mem[pos] = b;
		if (pos + 1 < eff) begin
			byte_pos = 7'(pos + 1);
			return;
		end
		off = b[3:0];
		word = {head_mem[off][6:0], head_mem[off+1], head_mem[off+2], head_mem[off+3]};
		modulus = 1;
		for (i = 0; i < digit_count && i < 15; i++)
			modulus = modulus * 10;
		code = word % modulus;
		for (i = OUTPUT_DIGITS; i > 0; i--) begin
			digits[i-1].ch = CHAR_W'(code % 10) + ASCII_ZERO;
			digits[i-1].last = (i == OUTPUT_DIGITS);
			code = code / 10;
		end
		for (i = 0; i < OUTPUT_DIGITS; i++)
			pending_digits.push_back(digits[i]);
		byte_pos = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		code_digit_t exp_digit;
		if (!arst_n) begin
			pending_digits.delete();
			digest_len = LEN_RESET;
			digit_count = CDIG_RESET;
			byte_pos = '0;
			mismatches = 0;
			foreach (head_mem[i])
				head_mem[i] = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_DIGEST_LENGTH: digest_len = pwdata[LEN_W-1:0];
					REG_CODE_DIGITS:   digit_count = pwdata[CDIG_W-1:0];
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_digits.size() == 0) begin
					$display("%0t: unexpected digit transaction: char %0d last %0b",
						$time, digit_char, last_digit);
					mismatches++;
				end else begin
					exp_digit = pending_digits.pop_front();
					if (digit_char !== exp_digit.ch) begin
						$display("%0t: digit_char expected %0d actual %0d",
							$time, exp_digit.ch, digit_char);
						mismatches++;
					end
					if (last_digit !== exp_digit.last) begin
						$display("%0t: last_digit expected %0b actual %0b",
							$time, exp_digit.last, last_digit);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				absorb_digest_byte(digest_byte);
		end
		errors <= mismatches;
		outstanding <= pending_digits.size();
	end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives digest bytes and register writes into the OTP truncation unit with
// random gaps and receiver stalls; a checker predicts and compares digits.
// ----------------------------------------------------------------------------
module testbench;
	import otpdt_pkg::*;

	localparam int TIMEOUT = 600000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        digest_byte;
	logic              out_valid;
	logic              out_ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;
	int                errors;
	int                outstanding;
	int                bytes_sent;
	bit                steady_in;

	otp_digest_truncate_to_digits_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .digest_byte(digest_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digit_char(digit_char), .last_digit(last_digit)
	);

	otpdt_digit_checker digit_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .digest_byte(digest_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digit_char(digit_char), .last_digit(last_digit),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#TIMEOUT;
		$display("otp_digest_truncate_to_digits_unit: mismatch");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		digest_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] pick_length();
		logic [31:0] v;
		logic [6:0]  len;
		int          r;
		v = $urandom;
		r = $urandom_range(0, 9);
		if (r < 6)
			len = 7'($urandom_range(20, 24));
		else if (r == 6)
			case ($urandom_range(0, 5))
				0: len = 7'd0;
				1: len = 7'd19;
				2: len = 7'd20;
				3: len = 7'd64;
				4: len = 7'd65;
				default: len = 7'd127;
			endcase
		else
			len = 7'($urandom_range(0, 127));
		v[6:0] = len;
		return v;
	endfunction

	// receiver: random stall before each digit, with stall-free stretches
	initial begin
		int stall;
		int count;
		bit steady_out;
		out_ready = 1'b0;
		count = 0;
		steady_out = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (count % 32 == 0)
				steady_out = ($urandom_range(0, 3) == 0);
			stall = steady_out ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			count++;
		end
	end

	initial begin
		int n;
		logic [31:0] v;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		digest_byte = '0;
		bytes_sent = 0;
		steady_in = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// length above the maximum acts as 64; stop partway into the digest
		reg_write(REG_DIGEST_LENGTH, 32'd127);
		reg_write(REG_CODE_DIGITS, 32'd15);
		for (int i = 0; i < 21; i++)
			send_byte((i % 2 == 0) ? 8'hff : ((i % 4 == 1) ? 8'h00 : 8'h80));
		drain();
		// length below the minimum, lowered under the current position:
		// next byte closes the digest, offset 15, no reduction
		reg_write(REG_DIGEST_LENGTH, 32'd0);
		send_byte(8'hff);
		drain();

		while (bytes_sent < 380) begin
			drain();
			if ($urandom_range(0, 2) != 0)
				reg_write(REG_DIGEST_LENGTH, pick_length());
			if ($urandom_range(0, 2) != 0) begin
				v = $urandom;
				v[3:0] = 4'($urandom_range(0, 15));
				reg_write(REG_CODE_DIGITS, v);
			end
			steady_in = ($urandom_range(0, 3) == 0);
			n = $urandom_range(1, 60);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
		end

		drain();
		repeat (40) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("otp_digest_truncate_to_digits_unit: match");
		else
			$display("otp_digest_truncate_to_digits_unit: mismatch");
		$finish;
	end

endmodule
